### rtl/core/key_state_edge_repeat_core_defines.svh
// Assertion macros for the key state tracker.
// Included by key_state_edge_repeat_core, which carries concurrent checks; no other dependencies.
`ifndef KEY_STATE_EDGE_REPEAT_CORE_DEFINES_SVH
`define KEY_STATE_EDGE_REPEAT_CORE_DEFINES_SVH

// Implication or plain property, sampled on the rising edge, off during reset.
`define KSER_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen.
`define KSER_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `KSER_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

### rtl/core/kser_pkg.sv
// Shared types and constants for the key state tracker.
// No dependencies; used by kser_cfg, the top level and the bench.
`timescale 1ns / 1ps

package kser_pkg;

  localparam int unsigned NumKeysDefault = 256;
  localparam int unsigned StepCount      = 7;
  localparam int unsigned CntW           = 16;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 16;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [CntW-1:0] CntSat = {{(CntW-1){1'b1}}, 1'b0};

  typedef enum logic [1:0] {
    OpDown  = 2'd0,
    OpUp    = 2'd1,
    OpTick  = 2'd2,
    OpQuery = 2'd3
  } op_e;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgEntriesUsed = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStep0       = 3'd1;

  localparam logic [2:0] EntriesReset = 3'd3;
  localparam logic [CntW-1:0] StepReset [StepCount] = '{
    16'd1, 16'd20, 16'd30, 16'd40, 16'd50, 16'd60, 16'd70
  };

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] key_index;
  } item_t;

  typedef struct packed {
    logic held;
    logic pressed_edge;
    logic released_edge;
    logic repeat_fire;
  } result_t;

  // One key's stored state
  typedef struct packed {
    logic            raw;
    logic            lvl_now;
    logic            lvl_before;
    logic [CntW-1:0] count;
  } entry_t;

endpackage

### rtl/core/kser_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kser_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/kser_cfg.sv
// Repeat table registers and the auto-repeat decision for one hold count.
// Depends on kser_pkg.
`timescale 1ns / 1ps

module kser_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kser_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kser_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [kser_pkg::CntW-1:0]     count_i,
  output logic                          fire_o
);

  logic [2:0]                  entries_q;
  logic [kser_pkg::CntW-1:0]   steps_q [kser_pkg::StepCount];
  logic [kser_pkg::CfgIdxW-1:0] step_sel;
  logic [2:0]                  used;
  logic [2:0]                  last_idx;
  logic                        any_hit;

  assign step_sel = cfg_idx_i - kser_pkg::CfgStep0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= kser_pkg::EntriesReset;
      for (int i = 0; i < kser_pkg::StepCount; i++) begin
        steps_q[i] <= kser_pkg::StepReset[i];
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == kser_pkg::CfgEntriesUsed) begin
        entries_q <= cfg_wdata_i[2:0];
      end else begin
        steps_q[step_sel] <= cfg_wdata_i[kser_pkg::CntW-1:0];
      end
    end
  end

  // An empty table behaves as a table of one
  assign used     = (entries_q == 3'd0) ? 3'd1 : entries_q;
  assign last_idx = used - 3'd1;

  always_comb begin
    any_hit = 1'b0;
    for (int i = 0; i < kser_pkg::StepCount; i++) begin
      if ((3'(i) < used) && (count_i == steps_q[i])) begin
        any_hit = 1'b1;
      end
    end
  end

  // At or past the last step, fire on every even count; below it, on a step match
  always_comb begin
    if (count_i == '0) begin
      fire_o = 1'b0;
    end else if (count_i >= steps_q[last_idx]) begin
      fire_o = ~count_i[0];
    end else begin
      fire_o = any_hit;
    end
  end

endmodule

### rtl/core/key_state_edge_repeat_core.sv
// Top level of the key state tracker: sequencer, key state RAM, repeat table.
// Depends on kser_pkg, kser_ram, kser_cfg and key_state_edge_repeat_core_defines.svh.
//
//   channel   direction  handshake                     payload
//   item      in         start high, busy low          item_i (operation, key_index)
//   result    out        res_strobe_o, one cycle       result_o (held, edges, repeat)
//   config    in         cfg_we_i, no wait             cfg_idx_i, cfg_wdata_i
//
// Down, up and query issue the RAM read on accept, then modify/write back or report.
// Tick sweeps every key: the sweep reads one key and writes back the
// previous one each cycle through the single RAM write port.
// One beat of result per item, in the first cycle with busy low; it cannot be held off.
// Reset clears control state and per-key valid flags; an entry not yet written
// reads as zero, so no clearing pass is needed.
`timescale 1ns / 1ps
`include "key_state_edge_repeat_core_defines.svh"

module key_state_edge_repeat_core #(
  parameter int unsigned NumKeys = kser_pkg::NumKeysDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  kser_pkg::item_t               item_i,
  output logic                          res_strobe_o,
  output kser_pkg::result_t             result_o,
  input  logic                          cfg_we_i,
  input  logic [kser_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kser_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned KeyW = (NumKeys > 1) ? $clog2(NumKeys) : 1;
  localparam int unsigned EntW = $bits(kser_pkg::entry_t);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StAccess = 3'b010,
    StSweep  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  kser_pkg::item_t   item_q;
  logic [KeyW-1:0]   ptr_q, ptr_d;
  logic [NumKeys-1:0] valid_q;
  logic              vld_rd_q;
  logic              strobe_q, strobe_d;
  kser_pkg::result_t result_q, result_d;

  logic              accept;
  logic              in_key_ok, q_key_ok;
  logic              rd_en, we;
  logic [KeyW-1:0]   rd_addr, wr_addr;
  logic [EntW-1:0]   ram_rdata;
  kser_pkg::entry_t  entry, tick_entry, acc_entry, wr_entry;
  logic              fire;
  logic              last_key;

  assign accept    = start && !busy;
  assign busy      = (state_q != StIdle);
  assign in_key_ok = ({1'b0, item_i.key_index} < 9'(NumKeys));
  assign q_key_ok  = ({1'b0, item_q.key_index} < 9'(NumKeys));
  assign last_key  = (ptr_q == KeyW'(NumKeys - 1));

  // Never-written entries read as the reset value
  assign entry = vld_rd_q ? kser_pkg::entry_t'(ram_rdata) : '0;

  always_comb begin
    tick_entry            = entry;
    tick_entry.lvl_before = entry.lvl_now;
    tick_entry.lvl_now    = entry.raw;
    if (!entry.raw) begin
      tick_entry.count = '0;
    end else if (entry.count == kser_pkg::CntMax) begin
      tick_entry.count = kser_pkg::CntSat;
    end else begin
      tick_entry.count = entry.count + kser_pkg::CntW'(1);
    end
  end

  always_comb begin
    acc_entry     = entry;
    acc_entry.raw = (item_q.operation == kser_pkg::OpDown);
  end

  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    strobe_d = 1'b0;
    result_d = '0;
    rd_en    = 1'b0;
    rd_addr  = item_i.key_index[KeyW-1:0];
    we       = 1'b0;
    wr_addr  = ptr_q;
    wr_entry = tick_entry;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (item_i.operation == kser_pkg::OpTick) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            ptr_d   = '0;
            state_d = StSweep;
          end else begin
            rd_en   = in_key_ok;
            state_d = StAccess;
          end
        end
      end
      StAccess: begin
        wr_addr  = item_q.key_index[KeyW-1:0];
        wr_entry = acc_entry;
        we       = q_key_ok && ((item_q.operation == kser_pkg::OpDown) ||
                                (item_q.operation == kser_pkg::OpUp));
        if (q_key_ok && (item_q.operation == kser_pkg::OpQuery)) begin
          result_d.held          = entry.lvl_now;
          result_d.pressed_edge  = entry.lvl_now & ~entry.lvl_before;
          result_d.released_edge = ~entry.lvl_now & entry.lvl_before;
          result_d.repeat_fire   = fire;
        end
        strobe_d = 1'b1;
        state_d  = StIdle;
      end
      StSweep: begin
        // Write back the key read last cycle, read the next one
        we = 1'b1;
        if (last_key) begin
          strobe_d = 1'b1;
          state_d  = StIdle;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_q + KeyW'(1);
          ptr_d   = ptr_q + KeyW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      strobe_q <= 1'b0;
      valid_q  <= '0;
      ptr_q    <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      ptr_q    <= ptr_d;
      if (we) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    if (accept) begin
      item_q <= item_i;
    end
    if (rd_en) begin
      vld_rd_q <= valid_q[rd_addr];
    end
  end

  kser_ram #(
    .Width (EntW),
    .Depth (NumKeys)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_addr),
    .wdata_i (EntW'(wr_entry)),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  kser_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .count_i     (entry.count),
    .fire_o      (fire)
  );

  assign res_strobe_o = strobe_q;
  assign result_o     = result_q;

  `KSER_ASSERT(a_strobe_src, clk_i, rst_ni,
    strobe_q |-> ($past(state_q) == StAccess) || ($past(state_q) == StSweep),
    "result beat without a finishing access or sweep")
  `KSER_ASSERT_NEVER(a_no_idle_write, clk_i, rst_ni, we && (state_q == StIdle),
    "RAM write while idle")
  `KSER_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> busy,
    "accepted item did not raise busy")
  `KSER_ASSERT(a_sweep_wb, clk_i, rst_ni,
    (we && (state_q == StSweep)) |-> (wr_addr == $past(rd_addr)) && $past(rd_en),
    "sweep write-back address differs from the key read before")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for key_state_edge_repeat_core: directed and random key commands
// run under several repeat-table settings. Depends on kser_pkg and the core RTL.

module tb;
  import kser_pkg::*;

  localparam int unsigned NumKeys       = NumKeysDefault;
  localparam int unsigned CycleLimit    = 2_000_000;
  localparam int unsigned TailCycles    = NumKeys + 8;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned ItemsPerPhase = 156;
  localparam logic [7:0]  LongKey       = 8'd200;
  localparam logic [7:0]  HotKeys [8]   = '{8'd0, 8'd1, 8'd2, 8'd3,
                                            8'd127, 8'd128, 8'd254, 8'd255};

  // Tracks per-key state and the repeat table, and holds the results still owed.
  class key_tracker_sb;
    logic [2:0]      entries;
    logic [CntW-1:0] steps    [StepCount];
    logic            raw_q    [NumKeys];
    logic            lvl_now  [NumKeys];
    logic            lvl_prev [NumKeys];
    logic [CntW-1:0] hold_cnt [NumKeys];
    result_t         due_results [$];
    int unsigned     errors;

    function new();
      entries = EntriesReset;
      foreach (steps[i]) steps[i] = StepReset[i];
      foreach (raw_q[i]) begin
        raw_q[i]    = 1'b0;
        lvl_now[i]  = 1'b0;
        lvl_prev[i] = 1'b0;
        hold_cnt[i] = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgEntriesUsed) entries = data[2:0];
      else steps[idx - CfgStep0] = data;
    endfunction

    function logic repeat_due(logic [CntW-1:0] cnt);
      int unsigned n;
      n = (entries == 3'd0) ? 1 : entries;
      if (cnt == '0) return 1'b0;
      // at or past the last step only even counts fire, even if the count hits a step
      if (cnt >= steps[n-1]) return ~cnt[0];
      for (int i = 0; i < n; i++) begin
        if (cnt == steps[i]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(item_t it);
      result_t     res;
      op_e         op;
      int unsigned k;
      res = '0;
      op  = op_e'(it.operation);
      k   = it.key_index;
      case (op)
        OpDown: if (k < NumKeys) raw_q[k] = 1'b1;
        OpUp:   if (k < NumKeys) raw_q[k] = 1'b0;
        OpTick: begin
          for (int i = 0; i < NumKeys; i++) begin
            lvl_prev[i] = lvl_now[i];
            lvl_now[i]  = raw_q[i];
            if (!lvl_now[i]) hold_cnt[i] = '0;
            else if (hold_cnt[i] == CntMax) hold_cnt[i] = CntSat;
            else hold_cnt[i] = hold_cnt[i] + 1'b1;
          end
        end
        default: begin
          if (k < NumKeys) begin
            res.held          = lvl_now[k];
            res.pressed_edge  = lvl_now[k] & ~lvl_prev[k];
            res.released_edge = ~lvl_now[k] & lvl_prev[k];
            res.repeat_fire   = repeat_due(hold_cnt[k]);
          end
        end
      endcase
      due_results.push_back(res);
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %b", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("held", want.held, got.held);
      compare_field("pressed_edge", want.pressed_edge, got.pressed_edge);
      compare_field("released_edge", want.released_edge, got.released_edge);
      compare_field("repeat_fire", want.repeat_fire, got.repeat_fire);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  item_t               item_i;
  logic                res_strobe_o;
  result_t             result_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  key_tracker_sb sb = new();
  int unsigned   cycles = 0;
  bit            quiet  = 1'b0;

  key_state_edge_repeat_core #(
    .NumKeys(NumKeys)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_strobe_o(res_strobe_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) sb.check_result(result_o);
  end

  task automatic send_item(item_t it);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
  endtask

  // Hold off the sender until every owed result beat has come back.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic program_table(int unsigned phase);
    logic [2:0]      n;
    logic [12:0]     junk;
    logic [CntW-1:0] s [StepCount];
    foreach (s[i]) s[i] = CntW'($urandom_range(1, 40));
    n    = 3'($urandom_range(0, 7));
    junk = 13'($urandom);
    case (phase)
      1: begin
        // single step at 1: every even count fires
        n    = 3'd1;
        s[0] = 16'd1;
      end
      2: begin
        n = 3'd7;
        foreach (s[i]) s[i] = CntW'(2 + 3 * i);
      end
      3: begin
        // zero entries behaves as one
        n    = 3'd0;
        s[0] = CntW'($urandom_range(2, 9));
      end
      4: begin
        // top of the table out of reach: only exact step matches fire
        n    = 3'd7;
        s[5] = 16'hFFFF;
        s[6] = 16'hFFFF;
      end
      6: begin
        // odd last step: parity rule wins over the exact match
        n    = 3'd4;
        s[3] = CntW'(2 * $urandom_range(2, 12) + 1);
      end
      default: ;
    endcase
    write_reg(CfgEntriesUsed, {junk, n});
    for (int i = 0; i < StepCount; i++) write_reg(CfgIdxW'(CfgStep0 + i), s[i]);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 99) < 85) return HotKeys[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Presses and ticks outnumber releases so holds build up; releases are rarer.
  function automatic item_t pick_item();
    item_t       it;
    int unsigned r;
    r            = $urandom_range(0, 99);
    it.key_index = pick_key();
    if (r < 20) it.operation = OpDown;
    else if (r < 30) it.operation = OpUp;
    else if (r < 60) it.operation = OpTick;
    else begin
      it.operation = OpQuery;
      if ($urandom_range(0, 9) == 0) it.key_index = LongKey;
    end
    return it;
  endfunction

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle keys, extreme indexes, first step, both edges
    send_item('{OpQuery, 8'd0});
    send_item('{OpQuery, 8'd255});
    send_item('{OpDown, 8'd0});
    send_item('{OpDown, 8'd255});
    send_item('{OpDown, LongKey});
    send_item('{OpQuery, 8'd0});
    send_item('{OpTick, 8'hA5});
    send_item('{OpQuery, 8'd0});
    send_item('{OpQuery, 8'd255});
    send_item('{OpTick, 8'd0});
    send_item('{OpQuery, 8'd0});
    send_item('{OpUp, 8'd0});
    send_item('{OpUp, 8'h5A});
    send_item('{OpDown, 8'hAA});
    send_item('{OpTick, 8'd255});
    send_item('{OpQuery, 8'd0});
    send_item('{OpQuery, 8'd255});
    send_item('{OpQuery, 8'hAA});
    send_item('{OpQuery, 8'h55});
    send_item('{OpTick, 8'h5A});
    send_item('{OpQuery, 8'd0});
    send_item('{OpQuery, 8'hAA});
    drain();

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      if (p != 0) program_table(p);
      quiet = (p == 3);
      for (int unsigned j = 0; j < ItemsPerPhase; j++) begin
        if (j == ItemsPerPhase / 2) drain();
        send_item(pick_item());
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
